>>> src/btd_pkg.sv
// ----------------------------------------------------------------------------
// btd_pkg
// shared constants, types and arithmetic helpers of the block texture decoder
// ----------------------------------------------------------------------------
package btd_pkg;

	// largest image side in pixels and the widths that follow from it
	localparam int MAX_DIM = 4096;
	localparam int CRD_W   = $clog2(MAX_DIM);
	localparam int BLK_W   = CRD_W - 2;
	localparam int BCNT_W  = BLK_W + 1;
	localparam int DIM_W   = 13;

	// configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_OPAQUE = CFG_IDX_W'(3);

	localparam logic [DIM_W-1:0] RST_WIDTH  = DIM_W'(256);
	localparam logic [DIM_W-1:0] RST_HEIGHT = DIM_W'(256);

	typedef enum logic [1:0] {
		FMT_DXT1 = 2'd0,
		FMT_DXT3 = 2'd1,
		FMT_DXT5 = 2'd2,
		FMT_RSVD = 2'd3
	} fmt_t;

	// block position and clip extent
	typedef struct packed {
		logic [BLK_W-1:0] bx;
		logic [BLK_W-1:0] by;
		logic [1:0]       last_col;
		logic [1:0]       last_row;
		logic             last_block;
	} pos_t;

	// accepted block as held in the input register
	typedef struct packed {
		logic [63:0] alpha_word;
		logic [63:0] color_word;
		pos_t        pos;
	} blk_t;

	// per-block palette and raw pixel data
	typedef struct packed {
		logic [7:0]       r0;
		logic [7:0]       g0;
		logic [7:0]       b0;
		logic [7:0]       r1;
		logic [7:0]       g1;
		logic [7:0]       b1;
		logic [7:0]       r2;
		logic [7:0]       g2;
		logic [7:0]       b2;
		logic             four;
		logic [7:0]       a0;
		logic [7:0]       a1;
		logic             amode8;
		logic [5:0][10:0] anum;
		logic [63:0]      alpha_word;
		logic [31:0]      idx;
		pos_t             pos;
	} pal_t;

	// one decoded pixel
	typedef struct packed {
		logic [CRD_W-1:0] x;
		logic [CRD_W-1:0] y;
		logic [7:0]       r;
		logic [7:0]       g;
		logic [7:0]       b;
		logic [7:0]       a;
		logic             block_done;
		logic             image_done;
	} pix_t;

	// floor(255*v/31) by fixed-point reciprocal
	function automatic logic [7:0] exp5(input logic [4:0] v);
		logic [24:0] p;
		p = {20'd0, v} * 25'd539088;
		return p[23:16];
	endfunction

	// floor(255*v/63) by fixed-point reciprocal
	function automatic logic [7:0] exp6(input logic [5:0] v);
		logic [24:0] p;
		p = {19'd0, v} * 25'd265266;
		return p[23:16];
	endfunction

	// floor(x/3), x up to 765
	function automatic logic [7:0] div3(input logic [9:0] x);
		logic [19:0] p;
		p = {10'd0, x} * 20'd683;
		return p[18:11];
	endfunction

	// floor(x/5), x up to 1275
	function automatic logic [7:0] div5(input logic [10:0] x);
		logic [21:0] p;
		p = {11'd0, x} * 22'd3277;
		return p[21:14];
	endfunction

	// floor(x/7), x up to 1785
	function automatic logic [7:0] div7(input logic [10:0] x);
		logic [21:0] p;
		p = {11'd0, x} * 22'd2341;
		return p[21:14];
	endfunction

endpackage

>>> src/btd_position.sv
// ----------------------------------------------------------------------------
// btd_position
// block column/row counters, image clipping extents and end-of-image flag
// ----------------------------------------------------------------------------
module btd_position (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [btd_pkg::DIM_W-1:0] width_raw,
	input  logic [btd_pkg::DIM_W-1:0] height_raw,
	input  logic                     advance,
	output btd_pkg::pos_t            pos
);

	logic [btd_pkg::BLK_W-1:0]  col_q;
	logic [btd_pkg::BLK_W-1:0]  row_q;
	logic [btd_pkg::CRD_W:0]    w;
	logic [btd_pkg::CRD_W:0]    h;
	logic [btd_pkg::CRD_W:0]    w_p3;
	logic [btd_pkg::CRD_W:0]    h_p3;
	logic [btd_pkg::BCNT_W-1:0] bw;
	logic [btd_pkg::BCNT_W-1:0] bh;
	logic                       stale;
	logic [btd_pkg::BLK_W-1:0]  cur_col;
	logic [btd_pkg::BLK_W-1:0]  cur_row;
	logic [btd_pkg::CRD_W:0]    rem_x;
	logic [btd_pkg::CRD_W:0]    rem_y;
	logic [btd_pkg::BCNT_W-1:0] nxt_col;
	logic [btd_pkg::BCNT_W-1:0] nxt_row;

	function automatic logic [btd_pkg::CRD_W:0] clamp_dim(input logic [btd_pkg::DIM_W-1:0] v);
		logic [btd_pkg::CRD_W:0] r;
		if (v == '0) begin
			r = (btd_pkg::CRD_W+1)'(1);
		end else if (32'(v) > 32'(btd_pkg::MAX_DIM)) begin
			r = (btd_pkg::CRD_W+1)'(btd_pkg::MAX_DIM);
		end else begin
			r = (btd_pkg::CRD_W+1)'(v);
		end
		return r;
	endfunction

	always_comb begin
		w     = clamp_dim(width_raw);
		h     = clamp_dim(height_raw);
		w_p3  = w + (btd_pkg::CRD_W+1)'(3);
		h_p3  = h + (btd_pkg::CRD_W+1)'(3);
		bw    = w_p3[btd_pkg::CRD_W:2];
		bh    = h_p3[btd_pkg::CRD_W:2];
		// counters left outside the grid by a register write restart at the origin
		stale = ({1'b0, col_q} >= bw) || ({1'b0, row_q} >= bh);
		cur_col = stale ? '0 : col_q;
		cur_row = stale ? '0 : row_q;
		rem_x = w - {1'b0, cur_col, 2'b00};
		rem_y = h - {1'b0, cur_row, 2'b00};
		pos.bx = cur_col;
		pos.by = cur_row;
		pos.last_col = (rem_x >= (btd_pkg::CRD_W+1)'(4)) ? 2'd3 : 2'(rem_x[1:0] - 2'd1);
		pos.last_row = (rem_y >= (btd_pkg::CRD_W+1)'(4)) ? 2'd3 : 2'(rem_y[1:0] - 2'd1);
		pos.last_block = ({1'b0, cur_col} == bw - btd_pkg::BCNT_W'(1))
			&& ({1'b0, cur_row} == bh - btd_pkg::BCNT_W'(1));
		nxt_col = {1'b0, cur_col} + btd_pkg::BCNT_W'(1);
		nxt_row = {1'b0, cur_row} + btd_pkg::BCNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (nxt_col >= bw) begin
				col_q <= '0;
				row_q <= (nxt_row >= bh) ? '0 : nxt_row[btd_pkg::BLK_W-1:0];
			end else begin
				col_q <= nxt_col[btd_pkg::BLK_W-1:0];
				row_q <= cur_row;
			end
		end
	end

endmodule

>>> src/btd_palette.sv
// ----------------------------------------------------------------------------
// btd_palette
// endpoint expansion and alpha interpolation terms, registered once per block
// ----------------------------------------------------------------------------
module btd_palette (
	input  logic                 clk,
	input  logic                 load,
	input  btd_pkg::fmt_t        fmt,
	input  btd_pkg::blk_t        blk,
	output btd_pkg::pal_t        pal
);

	btd_pkg::pal_t pal_d;
	logic [15:0]   c0;
	logic [15:0]   c1;
	logic [4:0]    r0f, b0f, r1f, b1f;
	logic [5:0]    g0f, g1f;
	logic [5:0]    r_sum, b_sum;
	logic [6:0]    g_sum;
	logic [8:0]    r_avg, g_avg, b_avg;
	logic          dxt1;

	always_comb begin
		c0   = blk.color_word[15:0];
		c1   = blk.color_word[31:16];
		r0f  = c0[15:11];
		g0f  = c0[10:5];
		b0f  = c0[4:0];
		r1f  = c1[15:11];
		g1f  = c1[10:5];
		b1f  = c1[4:0];
		dxt1 = (fmt == btd_pkg::FMT_DXT1);

		pal_d = '0;
		pal_d.r0 = dxt1 ? {r0f, 3'b000} : btd_pkg::exp5(r0f);
		pal_d.g0 = dxt1 ? {g0f, 2'b00}  : btd_pkg::exp6(g0f);
		pal_d.b0 = dxt1 ? {b0f, 3'b000} : btd_pkg::exp5(b0f);
		pal_d.r1 = dxt1 ? {r1f, 3'b000} : btd_pkg::exp5(r1f);
		pal_d.g1 = dxt1 ? {g1f, 2'b00}  : btd_pkg::exp6(g1f);
		pal_d.b1 = dxt1 ? {b1f, 3'b000} : btd_pkg::exp5(b1f);

		// three-colour midpoint: expanded average for dxt1, raw-field average otherwise
		r_avg = {1'b0, r0f, 3'b000} + {1'b0, r1f, 3'b000};
		g_avg = {1'b0, g0f, 2'b00} + {1'b0, g1f, 2'b00};
		b_avg = {1'b0, b0f, 3'b000} + {1'b0, b1f, 3'b000};
		r_sum = {1'b0, r0f} + {1'b0, r1f};
		g_sum = {1'b0, g0f} + {1'b0, g1f};
		b_sum = {1'b0, b0f} + {1'b0, b1f};
		pal_d.r2 = dxt1 ? r_avg[8:1] : btd_pkg::exp5(r_sum[5:1]);
		pal_d.g2 = dxt1 ? g_avg[8:1] : btd_pkg::exp6(g_sum[6:1]);
		pal_d.b2 = dxt1 ? b_avg[8:1] : btd_pkg::exp5(b_sum[5:1]);
		pal_d.four = (c0 > c1);

		pal_d.a0 = blk.alpha_word[7:0];
		pal_d.a1 = blk.alpha_word[15:8];
		pal_d.amode8 = (pal_d.a0 > pal_d.a1);
		// numerators for alpha codes two to seven
		for (int j = 0; j < 6; j++) begin
			if (pal_d.amode8) begin
				pal_d.anum[j] = 11'({3'b000, pal_d.a1} * 11'(j + 1))
					+ 11'({3'b000, pal_d.a0} * 11'(6 - j));
			end else if (j < 4) begin
				pal_d.anum[j] = 11'({3'b000, pal_d.a1} * 11'(j + 1))
					+ 11'({3'b000, pal_d.a0} * 11'(4 - j));
			end else begin
				pal_d.anum[j] = '0;
			end
		end

		pal_d.alpha_word = blk.alpha_word;
		pal_d.idx        = blk.color_word[63:32];
		pal_d.pos        = blk.pos;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pal <= pal_d;
		end
	end

endmodule

>>> src/btd_emit.sv
// ----------------------------------------------------------------------------
// btd_emit
// walks the in-image pixels of a block, one per beat, into the result register
// ----------------------------------------------------------------------------
module btd_emit (
	input  logic          clk,
	input  logic          arst_n,
	input  btd_pkg::pal_t pal,
	input  logic          pal_valid,
	input  btd_pkg::fmt_t fmt,
	input  logic          force_opaque,
	input  logic          pix_ready,
	output logic          pal_done,
	output btd_pkg::pix_t pix,
	output logic          pix_valid
);

	logic [1:0]    px_q;
	logic [1:0]    py_q;
	logic          adv;
	logic          last_px;
	logic          last_pix;
	logic [3:0]    pi;
	logic [1:0]    ci;
	logic [3:0]    nib;
	logic [5:0]    apos;
	logic [2:0]    ai;
	logic [2:0]    asel;
	btd_pkg::pix_t pix_d;

	function automatic logic [7:0] chan(
		input logic [7:0] p0,
		input logic [7:0] p1,
		input logic [7:0] p2,
		input logic       four,
		input logic [1:0] c
	);
		logic [7:0] r;
		unique case (c)
			2'd0: r = p0;
			2'd1: r = p1;
			2'd2: r = four ? btd_pkg::div3({1'b0, p0, 1'b0} + {2'b00, p1}) : p2;
			2'd3: r = four ? btd_pkg::div3({2'b00, p0} + {1'b0, p1, 1'b0}) : 8'd0;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	always_comb begin
		adv      = pal_valid && (!pix_valid || pix_ready);
		last_px  = (px_q == pal.pos.last_col);
		last_pix = last_px && (py_q == pal.pos.last_row);
		pal_done = adv && last_pix;

		pi   = {py_q, px_q};
		ci   = pal.idx[{pi, 1'b0} +: 2];
		nib  = pal.alpha_word[{pi, 2'b00} +: 4];
		apos = 6'd16 + {1'b0, pi, 1'b0} + {2'b00, pi};
		ai   = pal.alpha_word[apos +: 3];
		asel = 3'(ai - 3'd2);

		pix_d.x = {pal.pos.bx, px_q};
		pix_d.y = {pal.pos.by, py_q};
		pix_d.r = chan(pal.r0, pal.r1, pal.r2, pal.four, ci);
		pix_d.g = chan(pal.g0, pal.g1, pal.g2, pal.four, ci);
		pix_d.b = chan(pal.b0, pal.b1, pal.b2, pal.four, ci);
		pix_d.block_done = last_pix;
		pix_d.image_done = last_pix && pal.pos.last_block;

		priority if (fmt == btd_pkg::FMT_DXT1) begin
			pix_d.a = (!pal.four && ci == 2'd3) ? 8'd0 : 8'd255;
		end else if (force_opaque) begin
			pix_d.a = 8'd255;
		end else if (fmt == btd_pkg::FMT_DXT3) begin
			pix_d.a = {nib, nib};
		end else if (ai == 3'd0) begin
			pix_d.a = pal.a0;
		end else if (ai == 3'd1) begin
			pix_d.a = pal.a1;
		end else if (pal.amode8) begin
			pix_d.a = btd_pkg::div7(pal.anum[asel]);
		end else if (ai == 3'd6) begin
			pix_d.a = 8'd0;
		end else if (ai == 3'd7) begin
			pix_d.a = 8'd255;
		end else begin
			pix_d.a = btd_pkg::div5(pal.anum[asel]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q      <= '0;
			py_q      <= '0;
			pix_valid <= 1'b0;
		end else begin
			if (adv) begin
				pix_valid <= 1'b1;
				if (last_pix) begin
					px_q <= '0;
					py_q <= '0;
				end else if (last_px) begin
					px_q <= '0;
					py_q <= py_q + 2'd1;
				end else begin
					px_q <= px_q + 2'd1;
				end
			end else if (pix_ready) begin
				pix_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix <= pix_d;
		end
	end

endmodule

>>> src/block_texture_decoder.sv
// ----------------------------------------------------------------------------
// block_texture_decoder
// s3tc block decoder (dxt1, dxt3, dxt5) emitting clipped pixels with positions
// ----------------------------------------------------------------------------
// Compressed 4x4 blocks enter in raster block order, one per beat, as a
// 64-bit alpha word and a 64-bit colour word. Each block leaves as one beat
// per pixel that lies inside the image, in raster order within the block,
// carrying x, y, RGB and alpha; tlast marks the last pixel of the block and
// tuser additionally flags it when the block is the last of the image. The
// pixel walker gives one pixel per cycle unless m_tready stalls it; a block
// clipped at the right or bottom edge yields as many beats as it
// has visible pixels (1 to 16). Blocks pass an input register and a palette
// register before the walker, so a new block is taken while the previous
// one is still being emitted and the next block follows without a gap.
// An accepted block passes the input, palette and result registers on its
// way to the output. The block position counters wrap at the end of the
// image and are not cleared by register writes; if a write leaves them
// outside the new block grid they restart at the origin. Registers are to
// be written only while the decoder is idle.
// ----------------------------------------------------------------------------
module block_texture_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	// block input
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [127:0]                  s_tdata,   // alpha_word, color_word
	// pixel output
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [55:0]                   m_tdata,   // pixel_x, pixel_y, red, green, blue, alpha
	output logic                          m_tlast,   // block_done
	output logic                          m_tuser,   // image_done
	// register writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [btd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [btd_pkg::CFG_DATA_W-1:0] cfg_data
);

	// configuration registers
	btd_pkg::fmt_t             fmt_q;
	logic [btd_pkg::DIM_W-1:0] width_q;
	logic [btd_pkg::DIM_W-1:0] height_q;
	logic                      opaque_q;

	// block pipeline: input register then palette register
	btd_pkg::blk_t blk_s1;
	logic          s1_valid_q;
	logic          s2_valid_q;
	btd_pkg::pal_t pal_s2;
	btd_pkg::pos_t pos;
	logic          in_acc;
	logic          s2_load;
	logic          s1_move;
	logic          pal_done;
	btd_pkg::pix_t pix;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= btd_pkg::FMT_DXT1;
			width_q  <= btd_pkg::RST_WIDTH;
			height_q <= btd_pkg::RST_HEIGHT;
			opaque_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				btd_pkg::CFG_FORMAT: fmt_q    <= btd_pkg::fmt_t'(cfg_data[1:0]);
				btd_pkg::CFG_WIDTH:  width_q  <= cfg_data[btd_pkg::DIM_W-1:0];
				btd_pkg::CFG_HEIGHT: height_q <= cfg_data[btd_pkg::DIM_W-1:0];
				btd_pkg::CFG_OPAQUE: opaque_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// the palette register frees up in the cycle its last pixel enters the result register
	assign s2_load  = !s2_valid_q || pal_done;
	assign s1_move  = s1_valid_q && s2_load;
	assign s_tready = !s1_valid_q || s2_load;
	assign in_acc   = s_tvalid && s_tready;

	// position of the incoming block, advanced on every accepted beat
	btd_position u_position (
		.clk        (clk),
		.arst_n     (arst_n),
		.width_raw  (width_q),
		.height_raw (height_q),
		.advance    (in_acc),
		.pos        (pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				s1_valid_q <= 1'b1;
			end else if (s2_load) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_move) begin
				s2_valid_q <= 1'b1;
			end else if (pal_done) begin
				s2_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			blk_s1.alpha_word <= s_tdata[63:0];
			blk_s1.color_word <= s_tdata[127:64];
			blk_s1.pos        <= pos;
		end
	end

	// endpoint expansion and alpha terms
	btd_palette u_palette (
		.clk  (clk),
		.load (s1_move),
		.fmt  (fmt_q),
		.blk  (blk_s1),
		.pal  (pal_s2)
	);

	// per-pixel selection into the result register
	btd_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.pal          (pal_s2),
		.pal_valid    (s2_valid_q),
		.fmt          (fmt_q),
		.force_opaque (opaque_q),
		.pix_ready    (m_tready),
		.pal_done     (pal_done),
		.pix          (pix),
		.pix_valid    (m_tvalid)
	);

	assign m_tdata = {pix.a, pix.b, pix.g, pix.r, pix.y, pix.x};
	assign m_tlast = pix.block_done;
	assign m_tuser = pix.image_done;

endmodule

>>> src/btd_checker.sv
// ----------------------------------------------------------------------------
// btd_checker
// port-level checks of the block texture decoder, bound to the top level
// ----------------------------------------------------------------------------
module btd_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [55:0]  m_tdata,
	input logic         m_tlast,
	input logic         m_tuser
);

	// a stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("output beat changed while stalled");

	// end of image is only flagged on the last pixel of a block
	a_image_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("image_done without block_done");

	// consecutive pixels of one block share the block position
	a_same_block: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) ##1 (m_tvalid && m_tready)
			|-> (m_tdata[11:2] == $past(m_tdata[11:2]))
			&& (m_tdata[23:14] == $past(m_tdata[23:14])))
		else $error("pixel left its block before block_done");

	// the block after the last one of the image starts at the origin
	a_wrap_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tuser) ##1 (m_tvalid && m_tready)
			|-> m_tdata[23:0] == 24'd0)
		else $error("image did not wrap to the origin");

	// a block is never emitted from an empty pipeline right after reset
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !m_tvalid)
		else $error("output valid straight out of reset");

endmodule

bind block_texture_decoder btd_checker u_btd_checker (.*);
